FILE: rtl/core/vthp_pkg.sv
// ----------------------------------------------------------------------------
// vthp_pkg
// Types and constants shared by the video tag header parser.
// ----------------------------------------------------------------------------
package vthp_pkg;

	// one byte of a video tag, with its end-of-tag mark
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} tag_byte_t;

	// one parsed header
	typedef struct packed {
		logic               is_extended;
		logic [3:0]         frame_kind;
		logic [3:0]         pkt_kind;
		logic [31:0]        four_cc;
		logic signed [23:0] cts_offset;
		logic [3:0]         header_length;
		logic               status;
	} hdr_result_t;

	// status codes
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_TRUNC = 1'b1;

	// header lengths
	localparam logic [3:0] HLEN_NONE   = 4'd0;
	localparam logic [3:0] HLEN_LEGACY = 4'd1;
	localparam logic [3:0] HLEN_FOURCC = 4'd5;
	localparam logic [3:0] HLEN_CTIME  = 4'd8;

	// byte positions inside the header
	localparam logic [2:0] POS_FIRST    = 3'd0;
	localparam logic [2:0] POS_CC_FIRST = 3'd1;
	localparam logic [2:0] POS_CC_LAST  = 3'd4;
	localparam logic [2:0] POS_CT_FIRST = 3'd5;
	localparam logic [2:0] POS_CT_MID   = 3'd6;

	// codec tags that carry a composition time
	localparam logic [31:0] FOURCC_AVC1 = 32'h6176_6331;
	localparam logic [31:0] FOURCC_HVC1 = 32'h6876_6331;

	// reset value of the coded-frames packet type register
	localparam logic [3:0] CODED_FRAMES_RESET = 4'd1;

endpackage

FILE: rtl/core/video_tag_header_parser.sv
// ----------------------------------------------------------------------------
// video_tag_header_parser
// Parses legacy and extended video tag headers from a byte stream.
// ----------------------------------------------------------------------------
// Takes one tag byte per cycle on the byte channel and gives one header word
// per tag on the hdr channel, taken from the byte that completes the
// header (or ends the tag early): the byte is registered, then a single
// parse stage updates the header state and loads the result register. The
// parse stage handles one byte every cycle, so a tag streams at one byte per
// cycle with no gaps between tags; the byte channel stalls only when a
// finished header is held by the hdr channel. Payload bytes after a complete
// header are dropped up to the last byte of the tag. The coded-frames packet
// type is set through the cfg channel, which always accepts.
module video_tag_header_parser
	import vthp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// byte channel
	input  logic        byte_valid,
	output logic        byte_stall,
	input  tag_byte_t   byte_data,
	// header channel
	output logic        hdr_valid,
	input  logic        hdr_stall,
	output hdr_result_t hdr_data,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	logic        byte_valid_s1;
	tag_byte_t   byte_s1;
	logic        hdr_valid_s2;
	hdr_result_t hdr_s2;

	logic [3:0]  coded_type_q;
	logic [2:0]  pos_q, pos_n;
	logic [7:0]  first_byte_q, first_byte_n;
	logic [31:0] code_word_q, code_word_n;
	logic [15:0] time_hi_q, time_hi_n;
	logic        skip_q, skip_n;

	logic        advance;
	logic        byte_accept;
	logic        res_valid;
	hdr_result_t res;
	logic [7:0]  fb;

	// pipeline control
	assign advance     = !hdr_valid_s2 || !hdr_stall;
	assign byte_stall  = byte_valid_s1 && !advance;
	assign byte_accept = byte_valid && !byte_stall;
	assign cfg_ready   = 1'b1;
	assign hdr_valid   = hdr_valid_s2;
	assign hdr_data    = hdr_s2;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coded_type_q <= CODED_FRAMES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			coded_type_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (byte_accept) begin
			byte_valid_s1 <= 1'b1;
		end else if (advance) begin
			byte_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_accept) begin
			byte_s1 <= byte_data;
		end
	end

	// parse one byte against the header state
	always_comb begin
		logic done;
		done         = 1'b0;
		res_valid    = 1'b0;
		pos_n        = pos_q;
		first_byte_n = first_byte_q;
		code_word_n  = code_word_q;
		time_hi_n    = time_hi_q;
		skip_n       = skip_q;

		fb = (pos_q == POS_FIRST) ? byte_s1.data_byte : first_byte_q;
		res.is_extended   = fb[7];
		res.frame_kind    = fb[7] ? {1'b0, fb[6:4]} : fb[7:4];
		res.pkt_kind      = fb[7] ? fb[3:0] : 4'd0;
		res.four_cc       = '0;
		res.cts_offset    = '0;
		res.header_length = HLEN_NONE;
		res.status        = STATUS_TRUNC;

		if (skip_q) begin
			// payload bytes up to the end of the tag
			if (byte_s1.last_byte) begin
				skip_n = 1'b0;
				pos_n  = POS_FIRST;
			end
		end else if (pos_q == POS_FIRST) begin
			first_byte_n = byte_s1.data_byte;
			code_word_n  = '0;
			time_hi_n    = '0;
			if (!byte_s1.data_byte[7]) begin
				res.header_length = HLEN_LEGACY;
				res.status        = STATUS_OK;
				done              = 1'b1;
			end else if (byte_s1.last_byte) begin
				done = 1'b1;
			end else begin
				pos_n = POS_CC_FIRST;
			end
		end else if (pos_q <= POS_CC_LAST) begin
			code_word_n = {code_word_q[23:0], byte_s1.data_byte};
			if (pos_q != POS_CC_LAST) begin
				if (byte_s1.last_byte) begin
					done = 1'b1;
				end else begin
					pos_n = pos_q + 3'd1;
				end
			end else begin
				// fourcc complete
				res.four_cc       = code_word_n;
				res.header_length = HLEN_FOURCC;
				if ((first_byte_q[3:0] == coded_type_q) &&
				    (code_word_n inside {FOURCC_AVC1, FOURCC_HVC1})) begin
					if (byte_s1.last_byte) begin
						done = 1'b1;
					end else begin
						pos_n = POS_CT_FIRST;
					end
				end else begin
					res.status = STATUS_OK;
					done       = 1'b1;
				end
			end
		end else if (pos_q <= POS_CT_MID) begin
			time_hi_n         = {time_hi_q[7:0], byte_s1.data_byte};
			res.four_cc       = code_word_q;
			res.header_length = HLEN_FOURCC;
			if (byte_s1.last_byte) begin
				done = 1'b1;
			end else begin
				pos_n = pos_q + 3'd1;
			end
		end else begin
			// last composition time byte
			res.four_cc       = code_word_q;
			res.cts_offset    = {time_hi_q, byte_s1.data_byte};
			res.header_length = HLEN_CTIME;
			res.status        = STATUS_OK;
			done              = 1'b1;
		end

		if (done) begin
			res_valid = 1'b1;
			pos_n     = POS_FIRST;
			skip_n    = !byte_s1.last_byte;
		end
	end

	// header state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= POS_FIRST;
			first_byte_q <= '0;
			code_word_q  <= '0;
			time_hi_q    <= '0;
			skip_q       <= 1'b0;
		end else if (byte_valid_s1 && advance) begin
			pos_q        <= pos_n;
			first_byte_q <= first_byte_n;
			code_word_q  <= code_word_n;
			time_hi_q    <= time_hi_n;
			skip_q       <= skip_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_valid_s2 <= 1'b0;
		end else if (advance) begin
			hdr_valid_s2 <= byte_valid_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid_s1 && advance && res_valid) begin
			hdr_s2 <= res;
		end
	end

	// checks
	a_skip_at_start: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (pos_q == POS_FIRST))
		else $error("skipping payload away from the start of a tag");

	a_stall_needs_byte: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (byte_valid_s1 && hdr_valid_s2))
		else $error("byte channel stalled with nothing held");

	a_legacy_result: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_valid && !hdr_data.is_extended) |->
		(hdr_data.header_length == HLEN_LEGACY && hdr_data.pkt_kind == 4'd0 &&
		 hdr_data.status == STATUS_OK))
		else $error("malformed legacy header result");

	a_trunc_length: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_valid && hdr_data.status == STATUS_TRUNC) |->
		((hdr_data.header_length == HLEN_NONE ||
		  hdr_data.header_length == HLEN_FOURCC) &&
		 hdr_data.cts_offset == 24'sd0))
		else $error("truncated result with bad length or time");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(hdr_valid && hdr_stall) |=> (hdr_valid && $stable(hdr_data) &&
		 !(byte_valid_s1 && $past(byte_valid_s1) && pos_q != $past(pos_q))))
		else $error("parse state moved while result held");

endmodule
